@@ hw/rtl/jccd_pkg.sv @@
package jccd_pkg;

    localparam int NUM_AXES  = 4;
    localparam int AXIS_W    = 2;
    localparam int ADC_W     = 10;
    localparam int ADC_MAX   = 1023;
    localparam int DZ_W      = 9;
    localparam int CS_W      = 16;
    localparam int SUM_W     = 26;
    localparam int VAL_W     = 16;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 16;

    // signed working width for distance and span arithmetic
    localparam int SW_W = 12;

    localparam int DIV_W       = 26;
    localparam int DIVR_W      = 16;
    localparam int DIV_ITERS   = DIV_W / 2;
    localparam int DIV_CNT_W   = $clog2(DIV_ITERS);

    localparam logic [DZ_W-1:0]  DZ_RESET     = 9'd20;
    localparam logic [CS_W-1:0]  CS_RESET     = 16'd16;
    localparam logic [ADC_W-1:0] CENTER_RESET = 10'd512;
    localparam logic signed [VAL_W-1:0] Q15_FULL = 16'sd32767;
    localparam logic signed [SW_W-1:0]  ADC_MAX_S = SW_W'(ADC_MAX);

    localparam logic [CFG_IDX_W-1:0] REG_DEADZONE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CAL_SAMPLES = 2'd1;

    localparam logic [AXIS_W-1:0] LAST_AXIS = AXIS_W'(NUM_AXES - 1);

    typedef struct packed {
        logic              load_item;
        logic              cal_accum;
        logic              axis_eval;
        logic              axis_store;
        logic              cal_commit;
        logic              out_load;
        logic [AXIS_W-1:0] axis;
    } jccd_cmd_t;

    typedef struct packed {
        logic req_type;
        logic cal_complete;
        logic trivial;
        logic div_done;
        logic out_free;
    } jccd_stat_t;

endpackage

@@ hw/rtl/jccd_div.sv @@
module jccd_div (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           start,
    input  logic [jccd_pkg::DIV_W-1:0]     dividend,
    input  logic [jccd_pkg::DIVR_W-1:0]    divisor,
    output logic [jccd_pkg::DIV_W-1:0]     quotient,
    output logic                           done
);

    logic [jccd_pkg::DIVR_W-1:0]    rem_reg, rem_next;
    logic [jccd_pkg::DIV_W-1:0]     q_reg, q_next;
    logic [jccd_pkg::DIVR_W-1:0]    d_reg;
    logic [jccd_pkg::DIV_CNT_W-1:0] cnt_reg;
    logic                           busy_reg;
    logic                           done_reg;
    logic [jccd_pkg::DIVR_W:0]      step_a;
    logic [jccd_pkg::DIVR_W:0]      step_b;

    // one restoring step: returns {quotient bit, new remainder}
    function automatic logic [jccd_pkg::DIVR_W:0] div_step(
        input logic [jccd_pkg::DIVR_W-1:0] r,
        input logic                        b,
        input logic [jccd_pkg::DIVR_W-1:0] d
    );
        logic [jccd_pkg::DIVR_W:0] sh;
        logic [jccd_pkg::DIVR_W:0] diff;
        sh   = {r, b};
        diff = sh - {1'b0, d};
        if (sh >= {1'b0, d}) begin
            div_step = {1'b1, diff[jccd_pkg::DIVR_W-1:0]};
        end else begin
            div_step = {1'b0, sh[jccd_pkg::DIVR_W-1:0]};
        end
    endfunction

    // two quotient bits per cycle
    always_comb begin
        step_a   = div_step(rem_reg, q_reg[jccd_pkg::DIV_W-1], d_reg);
        step_b   = div_step(step_a[jccd_pkg::DIVR_W-1:0], q_reg[jccd_pkg::DIV_W-2], d_reg);
        rem_next = step_b[jccd_pkg::DIVR_W-1:0];
        q_next   = {q_reg[jccd_pkg::DIV_W-3:0], step_a[jccd_pkg::DIVR_W],
                    step_b[jccd_pkg::DIVR_W]};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= jccd_pkg::DIV_CNT_W'(jccd_pkg::DIV_ITERS - 1);
        end else if (busy_reg) begin
            if (cnt_reg == '0) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end else begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            q_reg   <= dividend;
            d_reg   <= divisor;
        end else if (busy_reg) begin
            rem_reg <= rem_next;
            q_reg   <= q_next;
        end
    end

    assign quotient = q_reg;
    assign done     = done_reg;

    a_no_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        start |-> !busy_reg)
        else $error("divider restarted while busy");

    a_done_not_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> !busy_reg)
        else $error("divider done while still iterating");

    a_quot_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (done_reg && !start) |=> $stable(q_reg))
        else $error("quotient changed after completion");

endmodule

@@ hw/rtl/jccd_datapath.sv @@
module jccd_datapath (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  jccd_pkg::jccd_cmd_t               cmd,
    output jccd_pkg::jccd_stat_t              stat,
    input  logic                              s_req_type,
    input  logic [jccd_pkg::ADC_W-1:0]        s_raw_lx,
    input  logic [jccd_pkg::ADC_W-1:0]        s_raw_ly,
    input  logic [jccd_pkg::ADC_W-1:0]        s_raw_rz,
    input  logic [jccd_pkg::ADC_W-1:0]        s_raw_ryaw,
    input  logic                              s_button1_level,
    input  logic                              s_button2_level,
    input  logic [jccd_pkg::ADC_W-1:0]        s_pot_sample,
    input  logic                              cfg_valid,
    input  logic                              cfg_ready,
    input  logic [jccd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [jccd_pkg::CFG_DAT_W-1:0]    cfg_data,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic signed [jccd_pkg::VAL_W-1:0] m_left_x,
    output logic signed [jccd_pkg::VAL_W-1:0] m_left_y,
    output logic signed [jccd_pkg::VAL_W-1:0] m_right_z,
    output logic signed [jccd_pkg::VAL_W-1:0] m_right_yaw,
    output logic                              m_button1_pressed,
    output logic                              m_button2_pressed,
    output logic [jccd_pkg::ADC_W-1:0]        m_pot_value,
    output logic                              m_cal_done
);

    logic                              req_reg;
    logic [jccd_pkg::ADC_W-1:0]        raw_reg [jccd_pkg::NUM_AXES];
    logic                              b1_reg, b2_reg;
    logic [jccd_pkg::ADC_W-1:0]        pot_reg;
    logic [jccd_pkg::DZ_W-1:0]         dz_reg;
    logic [jccd_pkg::CS_W-1:0]         cs_reg;
    logic [jccd_pkg::ADC_W-1:0]        center_reg [jccd_pkg::NUM_AXES];
    logic [jccd_pkg::SUM_W-1:0]        sum_reg [jccd_pkg::NUM_AXES];
    logic [jccd_pkg::CS_W-1:0]         count_reg;
    logic signed [jccd_pkg::VAL_W-1:0] val_reg [jccd_pkg::NUM_AXES];
    logic                              neg_reg;
    logic                              done_reg;
    logic                              m_valid_reg;

    logic [jccd_pkg::CS_W-1:0]         count_next;
    logic [jccd_pkg::CS_W-1:0]         target;
    logic [jccd_pkg::ADC_W-1:0]        raw_sel, ctr_sel;
    logic signed [jccd_pkg::SW_W-1:0]  delta, zs, den_pos, den_neg, den_sel, num_s;
    logic                              in_zone, pos, den_ok;
    logic [jccd_pkg::ADC_W-1:0]        num_u;
    logic [jccd_pkg::DIV_W-1:0]        prod;
    logic signed [jccd_pkg::VAL_W-1:0] triv_val, div_val;
    logic [jccd_pkg::VAL_W-2:0]        q_clamp;
    logic                              div_start;
    logic [jccd_pkg::DIV_W-1:0]        div_dividend, quot;
    logic [jccd_pkg::DIVR_W-1:0]       div_divisor;
    logic                              div_done;
    logic                              out_free;

    assign count_next = count_reg + 1'b1;
    assign target     = (cs_reg == '0) ? jccd_pkg::CS_W'(1) : cs_reg;
    assign out_free   = !m_valid_reg || m_ready;

    // per axis normalization terms
    always_comb begin
        raw_sel = raw_reg[cmd.axis];
        ctr_sel = center_reg[cmd.axis];
        delta   = $signed({2'b00, raw_sel}) - $signed({2'b00, ctr_sel});
        zs      = $signed({3'b000, dz_reg});
        in_zone = (delta <= zs) && (delta >= -zs);
        pos     = delta > 0;
        den_pos = jccd_pkg::ADC_MAX_S - $signed({2'b00, ctr_sel}) - zs;
        den_neg = $signed({2'b00, ctr_sel}) - zs;
        den_sel = pos ? den_pos : den_neg;
        den_ok  = den_sel > 0;
        num_s   = pos ? (delta - zs) : -(delta + zs);
        num_u   = num_s[jccd_pkg::ADC_W-1:0];
        // times 32767
        prod    = {1'b0, num_u, 15'b0} - jccd_pkg::DIV_W'(num_u);
        if (in_zone) begin
            triv_val = '0;
        end else if (pos) begin
            triv_val = jccd_pkg::Q15_FULL;
        end else begin
            triv_val = -jccd_pkg::Q15_FULL;
        end
        q_clamp = (quot > jccd_pkg::DIV_W'(jccd_pkg::Q15_FULL)) ?
                  jccd_pkg::Q15_FULL[jccd_pkg::VAL_W-2:0] : quot[jccd_pkg::VAL_W-2:0];
        div_val = neg_reg ? -$signed({1'b0, q_clamp}) : $signed({1'b0, q_clamp});
    end

    always_comb begin
        stat.req_type     = req_reg;
        stat.cal_complete = (count_next >= target) && (count_next != '0);
        stat.trivial      = req_reg && (in_zone || !den_ok);
        stat.div_done     = div_done;
        stat.out_free     = out_free;
    end

    assign div_start    = cmd.axis_eval && !stat.trivial;
    assign div_dividend = req_reg ? prod : sum_reg[cmd.axis];
    assign div_divisor  = req_reg ? {4'b0000, den_sel} : count_reg;

    jccd_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .quotient (quot),
        .done     (div_done)
    );

    // calibration state, configuration and output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dz_reg      <= jccd_pkg::DZ_RESET;
            cs_reg      <= jccd_pkg::CS_RESET;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
            for (int i = 0; i < jccd_pkg::NUM_AXES; i++) begin
                center_reg[i] <= jccd_pkg::CENTER_RESET;
                sum_reg[i]    <= '0;
            end
        end else begin
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    jccd_pkg::REG_DEADZONE:    dz_reg <= cfg_data[jccd_pkg::DZ_W-1:0];
                    jccd_pkg::REG_CAL_SAMPLES: cs_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (cmd.cal_accum) begin
                count_reg <= count_next;
                for (int i = 0; i < jccd_pkg::NUM_AXES; i++) begin
                    sum_reg[i] <= sum_reg[i] + jccd_pkg::SUM_W'(raw_reg[i]);
                end
            end
            if (cmd.axis_store && !req_reg) begin
                center_reg[cmd.axis] <= quot[jccd_pkg::ADC_W-1:0];
                sum_reg[cmd.axis]    <= '0;
            end
            if (cmd.cal_commit) begin
                count_reg <= '0;
            end
            if (cmd.out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // item and result payload
    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            req_reg    <= s_req_type;
            raw_reg[0] <= s_raw_lx;
            raw_reg[1] <= s_raw_ly;
            raw_reg[2] <= s_raw_rz;
            raw_reg[3] <= s_raw_ryaw;
            b1_reg     <= s_button1_level;
            b2_reg     <= s_button2_level;
            pot_reg    <= s_pot_sample;
            done_reg   <= 1'b0;
            for (int i = 0; i < jccd_pkg::NUM_AXES; i++) begin
                val_reg[i] <= '0;
            end
        end
        if (cmd.axis_eval) begin
            neg_reg <= !pos;
            if (stat.trivial) begin
                val_reg[cmd.axis] <= triv_val;
            end
        end
        if (cmd.axis_store && req_reg) begin
            val_reg[cmd.axis] <= div_val;
        end
        if (cmd.cal_commit) begin
            done_reg <= 1'b1;
        end
        if (cmd.out_load) begin
            m_left_x          <= val_reg[0];
            m_left_y          <= val_reg[1];
            m_right_z         <= val_reg[2];
            m_right_yaw       <= val_reg[3];
            m_button1_pressed <= !b1_reg;
            m_button2_pressed <= !b2_reg;
            m_pot_value       <= pot_reg;
            m_cal_done        <= done_reg;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

@@ hw/rtl/jccd_ctrl.sv @@
module jccd_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  jccd_pkg::jccd_stat_t stat,
    output jccd_pkg::jccd_cmd_t  cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CAL_ACC,
        ST_AXIS_SETUP,
        ST_AXIS_WAIT,
        ST_COMMIT,
        ST_OUT
    } state_t;

    state_t                      state_reg, state_next;
    logic [jccd_pkg::AXIS_W-1:0] axis_reg, axis_next;

    always_comb begin
        state_next     = state_reg;
        axis_next      = axis_reg;
        cmd            = '0;
        cmd.axis       = axis_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load_item = 1'b1;
                    axis_next     = '0;
                    state_next    = s_ready ? ST_CAL_ACC : ST_IDLE;
                end
            end
            // a run item goes straight to the axes, a calibration item first sums
            ST_CAL_ACC: begin
                if (stat.req_type) begin
                    state_next = ST_AXIS_SETUP;
                end else begin
                    cmd.cal_accum = 1'b1;
                    state_next    = stat.cal_complete ? ST_AXIS_SETUP : ST_OUT;
                end
            end
            ST_AXIS_SETUP: begin
                cmd.axis_eval = 1'b1;
                if (!stat.trivial) begin
                    state_next = ST_AXIS_WAIT;
                end else if (axis_reg == jccd_pkg::LAST_AXIS) begin
                    state_next = ST_OUT;
                end else begin
                    axis_next = axis_reg + 1'b1;
                end
            end
            ST_AXIS_WAIT: begin
                if (stat.div_done) begin
                    cmd.axis_store = 1'b1;
                    if (axis_reg == jccd_pkg::LAST_AXIS) begin
                        state_next = stat.req_type ? ST_OUT : ST_COMMIT;
                    end else begin
                        axis_next  = axis_reg + 1'b1;
                        state_next = ST_AXIS_SETUP;
                    end
                end
            end
            ST_COMMIT: begin
                cmd.cal_commit = 1'b1;
                state_next     = ST_OUT;
            end
            ST_OUT: begin
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            axis_reg  <= '0;
            s_ready   <= 1'b0;
        end else begin
            state_reg <= state_next;
            axis_reg  <= axis_next;
            s_ready   <= (state_next == ST_IDLE) && !(state_reg == ST_IDLE && s_valid && s_ready);
        end
    end

    a_out_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> stat.out_free)
        else $error("result loaded over an untaken result");

    a_commit_cal: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.cal_commit |-> !stat.req_type)
        else $error("center commit on a run item");

    a_wait_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_AXIS_WAIT && !stat.div_done) |=> state_reg == ST_AXIS_WAIT)
        else $error("left divide wait early");

    a_busy_not_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |-> !s_ready)
        else $error("ready while an item is in work");

endmodule

@@ hw/rtl/joystick_center_cal_deadzone.sv @@
// joystick center calibration and deadzone normalization
//
// input channel s_*: one item of four axis samples, two active-low button
// levels and a pot sample. req_type 0 is a calibration item, 1 a run item.
// result channel m_*: one result item per input item, in order.
// config channel cfg_*: index 0 deadzone, index 1 cal_samples; always ready.
// the user must write it only while the block is idle; the block does not enforce this.
//
// a run item makes one pass per axis through a shared restoring divider
// that retires two quotient bits a cycle; an axis that needs a divide
// is set up, divided and stored, and one that does not takes its fixed
// value (zero or full scale) without a divide.
// a calibration item only sums, but the item that completes
// the average runs the same divider over the four sums.
// one item is in work at a time; ready rises with result valid, so the
// next item may enter while that result waits.
// reset: centers 512, sums and count zero, deadzone 20, cal_samples 16,
// no result valid. when the receiver stalls the result holds in the output
// register and the block holds its next finished result until it is taken.
module joystick_center_cal_deadzone (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_req_type,
    input  logic [jccd_pkg::ADC_W-1:0]        s_raw_lx,
    input  logic [jccd_pkg::ADC_W-1:0]        s_raw_ly,
    input  logic [jccd_pkg::ADC_W-1:0]        s_raw_rz,
    input  logic [jccd_pkg::ADC_W-1:0]        s_raw_ryaw,
    input  logic                              s_button1_level,
    input  logic                              s_button2_level,
    input  logic [jccd_pkg::ADC_W-1:0]        s_pot_sample,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic signed [jccd_pkg::VAL_W-1:0] m_left_x,
    output logic signed [jccd_pkg::VAL_W-1:0] m_left_y,
    output logic signed [jccd_pkg::VAL_W-1:0] m_right_z,
    output logic signed [jccd_pkg::VAL_W-1:0] m_right_yaw,
    output logic                              m_button1_pressed,
    output logic                              m_button2_pressed,
    output logic [jccd_pkg::ADC_W-1:0]        m_pot_value,
    output logic                              m_cal_done,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [jccd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [jccd_pkg::CFG_DAT_W-1:0]    cfg_data
);

    jccd_pkg::jccd_cmd_t  cmd;
    jccd_pkg::jccd_stat_t stat;

    assign cfg_ready = 1'b1;

    jccd_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    jccd_datapath u_datapath (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cmd               (cmd),
        .stat              (stat),
        .s_req_type        (s_req_type),
        .s_raw_lx          (s_raw_lx),
        .s_raw_ly          (s_raw_ly),
        .s_raw_rz          (s_raw_rz),
        .s_raw_ryaw        (s_raw_ryaw),
        .s_button1_level   (s_button1_level),
        .s_button2_level   (s_button2_level),
        .s_pot_sample      (s_pot_sample),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_left_x          (m_left_x),
        .m_left_y          (m_left_y),
        .m_right_z         (m_right_z),
        .m_right_yaw       (m_right_yaw),
        .m_button1_pressed (m_button1_pressed),
        .m_button2_pressed (m_button2_pressed),
        .m_pot_value       (m_pot_value),
        .m_cal_done        (m_cal_done)
    );

endmodule
